// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check on every rising edge of clk outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== design/dnp_pkg.sv =====
// Types, character codes and defaults for the decimal number parser.
// No dependencies.
package dnp_pkg;

    localparam int MAX_LENGTH_DEF      = 255;
    localparam int FRACTION_DIGITS_DEF = 10;

    // Binary fraction bits and quotient bits resolved per divider stage
    localparam int QBITS      = 32;
    localparam int QSTEP      = 4;
    localparam int DIV_STAGES = QBITS / QSTEP;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [1:0] KIND_RESET   = 2'd2;
    localparam int         KIND_UNS_BIT = 0;
    localparam int         KIND_REAL_BIT = 1;

    localparam logic [31:0] INT_LIMIT = 32'h8000_0000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT,
        PH_DOT_INT,
        PH_FRAC,
        PH_DOT_FRAC
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first_char;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic signed [63:0] value;
        logic [7:0]        consumed;
        logic              saturated;
    } out_word_t;

    // Fields carried alongside the fraction divider
    typedef struct packed {
        logic        status;
        logic        negative;
        logic        clamp;
        logic [7:0]  consumed;
        logic [31:0] int_part;
    } meta_t;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// ===== design/decimal_number_parser.sv =====
// Decimal number parser: ASCII characters in, signed Q32.32 results out.
// Depends on dnp_pkg and assert_macros.svh.
// Usage:
//   in channel  (in_valid, in_stall, in_data): one character word per accept.
//     first_char starts a new number and abandons any parse in progress.
//   out channel (out_valid, out_stall, out_data): one result word per number,
//     produced when the first character not part of the number arrives.
//   cfg_we/cfg_data write number_kind (bit 0 unsigned, bit 1 real); write
//     only while no word is in flight.
// Timing:
//   One character is taken every cycle while in_stall is low. A result
//   is formed, once the character that ends the number is accepted, by an
//   entry stage, a divider pipeline of DIV_STAGES stages resolving QSTEP
//   bits each that turns the decimal fraction into binary, and an output
//   register loaded with the clamped, signed value.
// Stall:
//   While a result waits under out_stall the whole pipeline holds and
//   in_stall is raised in the same cycle; otherwise in_stall stays low.
// Reset:
//   rst_n clears all valid flags, the parse phase goes idle and number_kind
//   returns to signed real.
`include "assert_macros.svh"

module decimal_number_parser #(
    parameter int MAX_LENGTH      = dnp_pkg::MAX_LENGTH_DEF,
    parameter int FRACTION_DIGITS = dnp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  dnp_pkg::in_word_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output dnp_pkg::out_word_t out_data
);

    localparam int          NS    = dnp_pkg::DIV_STAGES;
    localparam int          QB    = dnp_pkg::QBITS;
    localparam logic [63:0] PMAX  = dnp_pkg::pow10(FRACTION_DIGITS);
    localparam int          PW    = $clog2(PMAX + 64'd1);
    localparam int          DW    = $clog2(FRACTION_DIGITS + 1);
    localparam int          CW    = $clog2(MAX_LENGTH + 1);
    localparam int          CXW   = (CW > 8) ? CW : 8;

    logic                 advance;
    logic                 accept;

    logic [1:0]           kind_reg;
    dnp_pkg::phase_t      phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          int_reg, int_next;
    logic [PW-1:0]        frac_reg, frac_next;
    logic [PW-1:0]        den_reg, den_next;
    logic [DW-1:0]        digits_reg, digits_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 clamp_reg, clamp_next;

    dnp_pkg::phase_t      eff_phase;
    logic                 eff_neg;
    logic [31:0]          eff_int;
    logic [PW-1:0]        eff_frac;
    logic [PW-1:0]        eff_den;
    logic [DW-1:0]        eff_digits;
    logic [CW-1:0]        eff_count;
    logic                 eff_clamp;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [CW-1:0]        count_p1;
    logic [CW-1:0]        count_p2;
    logic [CXW-1:0]       count_ext;
    logic [35:0]          int_sum;
    logic [PW+3:0]        frac_sum;
    logic [PW+3:0]        den_prod;
    logic                 emit;
    logic                 emit_err;

    logic                 valid_reg [0:NS];
    dnp_pkg::meta_t       meta_reg  [0:NS];
    logic [PW-1:0]        rem_reg   [0:NS];
    logic [PW-1:0]        dvs_reg   [0:NS];
    logic [QB-1:0]        quot_reg  [0:NS];
    logic [PW-1:0]        rem_next  [1:NS];
    logic [QB-1:0]        quot_next [1:NS];

    dnp_pkg::meta_t       entry_meta;
    logic [PW-1:0]        entry_rem;
    logic [PW-1:0]        entry_dvs;

    logic                 out_valid_reg;
    dnp_pkg::out_word_t   out_data_reg;
    dnp_pkg::out_word_t   result_next;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign accept    = in_valid && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        eff_phase  = in_data.first_char ? dnp_pkg::PH_INT : phase_reg;
        eff_neg    = in_data.first_char ? 1'b0 : neg_reg;
        eff_int    = in_data.first_char ? '0 : int_reg;
        eff_frac   = in_data.first_char ? '0 : frac_reg;
        eff_den    = in_data.first_char ? PW'(1) : den_reg;
        eff_digits = in_data.first_char ? '0 : digits_reg;
        eff_count  = in_data.first_char ? '0 : count_reg;
        eff_clamp  = in_data.first_char ? 1'b0 : clamp_reg;
    end

    always_comb
    begin
        is_digit = (in_data.ch >= dnp_pkg::CHAR_ZERO) && (in_data.ch <= dnp_pkg::CHAR_NINE);
        digit    = 4'(in_data.ch - dnp_pkg::CHAR_ZERO);
        count_p1 = ((CW+1)'(eff_count) + (CW+1)'(1) > (CW+1)'(MAX_LENGTH))
                   ? CW'(MAX_LENGTH) : CW'(eff_count + CW'(1));
        count_p2 = ((CW+1)'(eff_count) + (CW+1)'(2) > (CW+1)'(MAX_LENGTH))
                   ? CW'(MAX_LENGTH) : CW'(eff_count + CW'(2));
        count_ext = CXW'(eff_count);
        int_sum  = ({4'b0, eff_int} << 3) + ({4'b0, eff_int} << 1) + 36'(digit);
        frac_sum = ((PW+4)'(eff_frac) << 3) + ((PW+4)'(eff_frac) << 1) + (PW+4)'(digit);
        den_prod = ((PW+4)'(eff_den) << 3) + ((PW+4)'(eff_den) << 1);
    end

    always_comb
    begin
        phase_next  = eff_phase;
        neg_next    = eff_neg;
        int_next    = eff_int;
        frac_next   = eff_frac;
        den_next    = eff_den;
        digits_next = eff_digits;
        count_next  = eff_count;
        clamp_next  = eff_clamp;
        emit        = 1'b0;
        emit_err    = 1'b0;

        if (in_data.first_char && in_data.ch == dnp_pkg::CHAR_MINUS)
        begin
            if (kind_reg[dnp_pkg::KIND_UNS_BIT])
            begin
                emit       = 1'b1;
                emit_err   = 1'b1;
                phase_next = dnp_pkg::PH_IDLE;
            end
            else
            begin
                neg_next   = 1'b1;
                count_next = count_p1;
            end
        end
        else
        begin
            unique case (eff_phase)
                dnp_pkg::PH_IDLE:
                begin
                end
                dnp_pkg::PH_INT:
                begin
                    if (is_digit)
                    begin
                        if (int_sum > 36'(dnp_pkg::INT_LIMIT))
                        begin
                            int_next   = dnp_pkg::INT_LIMIT;
                            clamp_next = 1'b1;
                        end
                        else
                        begin
                            int_next = int_sum[31:0];
                        end
                        count_next = count_p1;
                    end
                    else if (in_data.ch == dnp_pkg::CHAR_DOT)
                    begin
                        phase_next = dnp_pkg::PH_DOT_INT;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        emit_err   = (eff_count == '0);
                        phase_next = dnp_pkg::PH_IDLE;
                    end
                end
                dnp_pkg::PH_DOT_INT:
                begin
                    if (!is_digit || !kind_reg[dnp_pkg::KIND_REAL_BIT])
                    begin
                        emit       = 1'b1;
                        emit_err   = 1'b1;
                        phase_next = dnp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (eff_digits < DW'(FRACTION_DIGITS))
                        begin
                            frac_next   = PW'(frac_sum);
                            den_next    = PW'(den_prod);
                            digits_next = eff_digits + DW'(1);
                        end
                        count_next = count_p2;
                        phase_next = dnp_pkg::PH_FRAC;
                    end
                end
                dnp_pkg::PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (eff_digits < DW'(FRACTION_DIGITS))
                        begin
                            frac_next   = PW'(frac_sum);
                            den_next    = PW'(den_prod);
                            digits_next = eff_digits + DW'(1);
                        end
                        count_next = count_p1;
                    end
                    else if (in_data.ch == dnp_pkg::CHAR_DOT)
                    begin
                        phase_next = dnp_pkg::PH_DOT_FRAC;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        phase_next = dnp_pkg::PH_IDLE;
                    end
                end
                dnp_pkg::PH_DOT_FRAC:
                begin
                    emit       = 1'b1;
                    emit_err   = !is_digit;
                    phase_next = dnp_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = dnp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit_err)
        begin
            entry_meta = '{status: 1'b1, negative: 1'b0, clamp: 1'b0,
                           consumed: 8'd0, int_part: 32'd0};
            entry_rem  = '0;
            entry_dvs  = PW'(1);
        end
        else
        begin
            entry_meta.status   = 1'b0;
            entry_meta.negative = eff_neg;
            entry_meta.clamp    = eff_clamp;
            entry_meta.consumed = (count_ext > CXW'(255)) ? 8'hFF : count_ext[7:0];
            entry_meta.int_part = eff_int;
            entry_rem           = eff_frac;
            entry_dvs           = eff_den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= dnp_pkg::KIND_RESET;
            phase_reg <= dnp_pkg::PH_IDLE;
        end
        else
        begin
            if (cfg_we)
            begin
                kind_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg    <= neg_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            den_reg    <= den_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
            clamp_reg  <= clamp_next;
        end
    end

    // Fraction divider: each stage resolves QSTEP quotient bits
    always_comb
    begin
        logic [PW-1:0] r;
        logic [QB-1:0] q;
        logic [PW:0]   t;
        for (int s = 0; s < NS; s++)
        begin
            r = rem_reg[s];
            q = quot_reg[s];
            for (int b = 0; b < dnp_pkg::QSTEP; b++)
            begin
                t = {r, 1'b0};
                if (t >= {1'b0, dvs_reg[s]})
                begin
                    r = PW'(t - {1'b0, dvs_reg[s]});
                    q = {q[QB-2:0], 1'b1};
                end
                else
                begin
                    r = PW'(t);
                    q = {q[QB-2:0], 1'b0};
                end
            end
            rem_next[s+1]  = r;
            quot_next[s+1] = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= accept && emit;
            for (int s = 1; s <= NS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            out_valid_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meta_reg[0] <= entry_meta;
            rem_reg[0]  <= entry_rem;
            dvs_reg[0]  <= entry_dvs;
            quot_reg[0] <= '0;
            for (int s = 1; s <= NS; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
                dvs_reg[s]  <= dvs_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
            end
            out_data_reg <= result_next;
        end
    end

    // Clamp the magnitude and apply the sign
    always_comb
    begin
        logic [63:0] mag;
        logic        over;
        mag  = {meta_reg[NS].int_part, quot_reg[NS]};
        over = (meta_reg[NS].int_part == dnp_pkg::INT_LIMIT)
               && (!meta_reg[NS].negative || quot_reg[NS] != '0);
        if (over)
        begin
            mag = meta_reg[NS].negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        result_next.status    = meta_reg[NS].status;
        result_next.value     = meta_reg[NS].negative ? -mag : mag;
        result_next.consumed  = meta_reg[NS].consumed;
        result_next.saturated = meta_reg[NS].clamp || over;
    end

    `ASSERT_RST(a_err_zero, out_valid && out_data.status |-> out_data.value == 64'sd0 && out_data.consumed == 8'd0 && !out_data.saturated, "error result carries nonzero fields")
    `ASSERT_RST(a_ok_consumed, out_valid && !out_data.status |-> out_data.consumed != 8'd0, "success result with nothing consumed")
    `ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")
    `ASSERT_RST(a_idle_silent, in_valid && !in_stall && !in_data.first_char && phase_reg == dnp_pkg::PH_IDLE |=> !valid_reg[0], "idle character produced a result")
    `ASSERT_RST(a_hold_pipe, out_valid && out_stall |=> $stable(valid_reg[NS]), "divider pipeline moved while output held")

endmodule
